/* src/bts_pkg.sv */
// Shared types, constants and the tanh lookup table for the biased tanh saturator.
// Used by every module and interface of the block; depends on nothing else.
package bts_pkg;

    // Sample format and table size.
    localparam int SAMPLE_W = 16;
    localparam int TANH_N   = 256;

    // Configuration register widths.
    localparam int GAIN_W     = 15;
    localparam int DRIVE_W    = 16;
    localparam int BIAS_W     = 16;
    localparam int SCALE_W    = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_INDEX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_GAIN   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_AMOUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS_OFFSET  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_SCALE = 2'd3;

    // Reset values: gain 1.2, drive 0.8, bias 0.1, output scale from software.
    localparam logic [GAIN_W-1:0]         RST_INPUT_GAIN   = 15'd4915;
    localparam logic [DRIVE_W-1:0]        RST_DRIVE_AMOUNT = 16'd13107;
    localparam logic signed [BIAS_W-1:0]  RST_BIAS_OFFSET  = 16'sd3277;
    localparam logic [SCALE_W-1:0]        RST_OUTPUT_SCALE = 20'd5551;

    // Front end widths.
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
    localparam int V_W    = 48;
    localparam int MAG_W  = V_W - 16;
    localparam int Q_W    = MAG_W + DRIVE_W;

    // Table position: the product times TANH_N, integer part from bit 43 up.
    localparam int IDX_W     = $clog2(TANH_N + 1);
    localparam int P_W       = Q_W + IDX_W;
    localparam int POS_SHIFT = 43;
    localparam int FRAC_LSB  = 27;
    localparam int FRAC_W    = 16;
    localparam int POS_HI_W  = P_W - POS_SHIFT;
    localparam int LERP_W    = 2 * FRAC_W + 1;
    localparam int LERP_RND  = 1 << (FRAC_W - 1);

    // Table entries are Q1.15 magnitudes up to exactly 1.0.
    localparam int ROM_W     = 16;
    localparam int TANH_ONE  = 32768;

    // Back end: y * scale is Q.27 and is rounded or widened to the sample fraction.
    localparam int R_W         = ROM_W + SCALE_W;
    localparam int OUT_SHIFT_R = (SAMPLE_W <= 28) ? (28 - SAMPLE_W) : 0;
    localparam int OUT_SHIFT_L = (SAMPLE_W > 28) ? (SAMPLE_W - 28) : 0;
    localparam int OUT_RND     = (1 << OUT_SHIFT_R) >> 1;
    localparam int OUT_MAG_W   = R_W + 1 + OUT_SHIFT_L;

    typedef struct packed {
        logic [GAIN_W-1:0]        input_gain;
        logic [DRIVE_W-1:0]       drive_amount;
        logic signed [BIAS_W-1:0] bias_offset;
        logic [SCALE_W-1:0]       output_scale;
    } cfg_t;

    // Word passed from the front end to the table stage.
    typedef struct packed {
        logic           neg;
        logic [Q_W-1:0] q;
    } front_t;

    // Word passed from the table stage to the back end.
    typedef struct packed {
        logic             neg;
        logic [ROM_W-1:0] y;
    } shaped_t;

    typedef logic [ROM_W-1:0] tanh_rom_t [0:TANH_N];

    // Floor quotient by restoring long division, one quotient bit per step.
    function automatic logic [63:0] div_floor(input logic [63:0] num,
                                              input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds tanh(4i/N) in Q1.15. Each point starts from t - t^3/3 at 1/1024 of
    // the argument in Q2.30 and doubles ten times with t <- 2t/(1+t^2).
    // Evaluated once at elaboration.
    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t   rom;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] t3;
        logic [63:0] den;
        logic [63:0] q;
        logic [63:0] prev;
        prev = '0;
        for (int i = 0; i <= TANH_N; i++)
        begin
            x  = div_floor(64'(i) << 32, 64'(TANH_N));
            t  = x >> 10;
            t3 = (((t * t) >> 30) * t) >> 30;
            t  = t - div_floor(t3, 64'd3);
            for (int k = 0; k < 10; k++)
            begin
                den = (64'd1 << 30) + ((t * t) >> 30);
                t   = div_floor(t << 31, den);
            end
            q = (t + 64'd16384) >> 15;
            if (q > 64'(TANH_ONE))
            begin
                q = 64'(TANH_ONE);
            end
            if (q < prev)
            begin
                q = prev;
            end
            rom[i] = q[ROM_W-1:0];
            prev   = q;
        end
        return rom;
    endfunction

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

/* src/bts_sample_if.sv */
// Input channel of the saturator: one signed sample per word.
// Depends on bts_pkg for the sample width.
interface bts_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [bts_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

/* src/bts_result_if.sv */
// Output channel of the saturator: one saturated sample per word.
// Depends on bts_pkg for the sample width.
interface bts_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [bts_pkg::SAMPLE_W-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

/* src/bts_front.sv */
// Front end: input gain, bias, magnitude and drive, three register stages.
// Depends on bts_pkg.
module bts_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bts_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [bts_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  logic                                out_ready,
    output bts_pkg::front_t                     out_data
);

    logic                                 v1_reg;
    logic                                 v2_reg;
    logic                                 v3_reg;
    logic                                 ready1;
    logic                                 ready2;
    logic                                 ready3;

    logic signed [bts_pkg::PROD_W-1:0]    prod_next;
    logic signed [bts_pkg::PROD_W-1:0]    prod_reg;
    logic signed [bts_pkg::V_W-1:0]       v_sum;
    logic [bts_pkg::V_W-1:0]              v_abs;
    logic                                 neg_next;
    logic [bts_pkg::MAG_W-1:0]            mag_next;
    logic                                 neg2_reg;
    logic [bts_pkg::MAG_W-1:0]            mag_reg;
    logic [bts_pkg::Q_W-1:0]              q_next;
    logic                                 neg3_reg;
    logic [bts_pkg::Q_W-1:0]              q_reg;

    // A stage takes a new word when it is empty or its word moves on.
    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_comb
    begin
        prod_next = bts_pkg::PROD_W'(sample)
                  * bts_pkg::PROD_W'($signed({1'b0, cfg.input_gain}));
    end

    // The Q1.31 sample times the Q4.12 gain is Q.43; the bias is aligned to it.
    always_comb
    begin
        v_sum = (bts_pkg::V_W'(prod_reg) <<< (32 - bts_pkg::SAMPLE_W))
              + (bts_pkg::V_W'(cfg.bias_offset) <<< 28);
        neg_next = v_sum[bts_pkg::V_W-1];
        v_abs    = neg_next ? -v_sum : v_sum;
        mag_next = v_abs[bts_pkg::V_W-1:16];
    end

    always_comb
    begin
        q_next = bts_pkg::Q_W'(mag_reg) * bts_pkg::Q_W'(cfg.drive_amount);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (ready2 && v1_reg)
        begin
            neg2_reg <= neg_next;
            mag_reg  <= mag_next;
        end
        if (ready3 && v2_reg)
        begin
            neg3_reg <= neg2_reg;
            q_reg    <= q_next;
        end
    end

    assign out_valid    = v3_reg;
    assign out_data.neg = neg3_reg;
    assign out_data.q   = q_reg;

endmodule

/* src/bts_tanh.sv */
// Table stage: locates the tanh argument in the table and interpolates
// linearly between neighbors, two register stages. Depends on bts_pkg.
module bts_tanh (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bts_pkg::front_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bts_pkg::shaped_t  out_data
);

    logic                               v4_reg;
    logic                               v5_reg;
    logic                               ready4;
    logic                               ready5;

    logic [bts_pkg::P_W-1:0]            pos;
    logic [bts_pkg::POS_HI_W-1:0]       pos_hi;
    logic                               sat_next;
    logic [bts_pkg::IDX_W-1:0]          idx;
    logic [bts_pkg::IDX_W-1:0]          idx_up;
    logic [bts_pkg::ROM_W-1:0]          a_next;
    logic [bts_pkg::ROM_W-1:0]          diff_next;
    logic [bts_pkg::FRAC_W-1:0]         frac_next;

    logic                               neg4_reg;
    logic                               sat_reg;
    logic [bts_pkg::ROM_W-1:0]          a_reg;
    logic [bts_pkg::ROM_W-1:0]          diff_reg;
    logic [bts_pkg::FRAC_W-1:0]         frac_reg;

    logic [bts_pkg::LERP_W-1:0]         lerp;
    logic [bts_pkg::ROM_W-1:0]          y_next;
    logic                               neg5_reg;
    logic [bts_pkg::ROM_W-1:0]          y_reg;

    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign in_ready = ready4;

    // Beyond the last table point the magnitude is exactly one; the index is
    // then parked at zero so that the upper neighbor stays inside the table.
    always_comb
    begin
        pos       = bts_pkg::P_W'(in_data.q) * bts_pkg::P_W'(bts_pkg::TANH_N);
        pos_hi    = pos[bts_pkg::P_W-1:bts_pkg::POS_SHIFT];
        sat_next  = pos_hi >= bts_pkg::POS_HI_W'(bts_pkg::TANH_N);
        idx       = sat_next ? '0 : pos_hi[bts_pkg::IDX_W-1:0];
        idx_up    = idx + 1'b1;
        a_next    = bts_pkg::TANH_ROM[idx];
        diff_next = bts_pkg::TANH_ROM[idx_up] - a_next;
        frac_next = pos[bts_pkg::FRAC_LSB+bts_pkg::FRAC_W-1:bts_pkg::FRAC_LSB];
    end

    always_comb
    begin
        lerp = bts_pkg::LERP_W'(diff_reg) * bts_pkg::LERP_W'(frac_reg)
             + bts_pkg::LERP_W'(bts_pkg::LERP_RND);
        if (sat_reg)
        begin
            y_next = bts_pkg::ROM_W'(bts_pkg::TANH_ONE);
        end
        else
        begin
            y_next = a_reg + bts_pkg::ROM_W'(lerp >> bts_pkg::FRAC_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (ready4)
            begin
                v4_reg <= in_valid;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4 && in_valid)
        begin
            neg4_reg <= in_data.neg;
            sat_reg  <= sat_next;
            a_reg    <= a_next;
            diff_reg <= diff_next;
            frac_reg <= frac_next;
        end
        if (ready5 && v4_reg)
        begin
            neg5_reg <= neg4_reg;
            y_reg    <= y_next;
        end
    end

    assign out_valid    = v5_reg;
    assign out_data.neg = neg5_reg;
    assign out_data.y   = y_reg;

endmodule

/* src/bts_back.sv */
// Back end: output scale, rounding, sign and saturation, ending in the
// output register. Depends on bts_pkg.
module bts_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bts_pkg::cfg_t                       cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  bts_pkg::shaped_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [bts_pkg::SAMPLE_W-1:0] sample
);

    localparam logic [bts_pkg::OUT_MAG_W-1:0] LIM_NEG =
        bts_pkg::OUT_MAG_W'(1) << (bts_pkg::SAMPLE_W - 1);
    localparam logic [bts_pkg::OUT_MAG_W-1:0] LIM_POS =
        LIM_NEG - bts_pkg::OUT_MAG_W'(1);

    logic                                 v6_reg;
    logic                                 v7_reg;
    logic                                 ready6;
    logic                                 ready7;

    logic [bts_pkg::R_W-1:0]              r_next;
    logic                                 neg6_reg;
    logic [bts_pkg::R_W-1:0]              r_reg;

    logic [bts_pkg::OUT_MAG_W-1:0]        mag;
    logic signed [bts_pkg::SAMPLE_W-1:0]  sample_next;
    logic signed [bts_pkg::SAMPLE_W-1:0]  sample_reg;

    assign ready7   = !v7_reg || out_ready;
    assign ready6   = !v6_reg || ready7;
    assign in_ready = ready6;

    always_comb
    begin
        r_next = bts_pkg::R_W'(in_data.y) * bts_pkg::R_W'(cfg.output_scale);
    end

    // The magnitude is rounded half up before the sign goes back on, so the
    // negative side rounds away from zero.
    always_comb
    begin
        mag = ((bts_pkg::OUT_MAG_W'(r_reg) + bts_pkg::OUT_MAG_W'(bts_pkg::OUT_RND))
               >> bts_pkg::OUT_SHIFT_R) << bts_pkg::OUT_SHIFT_L;
        if (neg6_reg)
        begin
            if (mag >= LIM_NEG)
            begin
                sample_next = bts_pkg::SAMPLE_W'(LIM_NEG);
            end
            else
            begin
                sample_next = -bts_pkg::SAMPLE_W'(mag);
            end
        end
        else
        begin
            if (mag >= LIM_POS)
            begin
                sample_next = bts_pkg::SAMPLE_W'(LIM_POS);
            end
            else
            begin
                sample_next = bts_pkg::SAMPLE_W'(mag);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            if (ready6)
            begin
                v6_reg <= in_valid;
            end
            if (ready7)
            begin
                v7_reg <= v6_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready6 && in_valid)
        begin
            neg6_reg <= in_data.neg;
            r_reg    <= r_next;
        end
        if (ready7 && v6_reg)
        begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid = v7_reg;
    assign sample    = sample_reg;

endmodule

/* src/biased_tanh_saturator_core.sv */
// Throughput: one word per cycle while the result stream is not stalled; seven
// register stages, each with its own valid bit, and a stage fills whenever it is
// empty or its word moves on.
// Reset clears every valid bit and loads the configuration defaults
// (gain 1.2, drive 0.8, bias 0.1, output scale 5551); no clearing pass.
// Depends on bts_pkg, bts_sample_if, bts_result_if, bts_front, bts_tanh, bts_back.
module biased_tanh_saturator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    bts_sample_if.sink                            sample_stream,
    bts_result_if.source                          result_stream,
    input  logic                                  cfg_we,
    input  logic [bts_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]        cfg_data
);

    bts_pkg::cfg_t     cfg_reg;
    bts_pkg::cfg_t     cfg_next;

    logic              front_valid;
    logic              front_ready;
    bts_pkg::front_t   front_data;
    logic              shaped_valid;
    logic              shaped_ready;
    bts_pkg::shaped_t  shaped_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bts_pkg::REG_INPUT_GAIN:
                    cfg_next.input_gain   = cfg_data[bts_pkg::GAIN_W-1:0];
                bts_pkg::REG_DRIVE_AMOUNT:
                    cfg_next.drive_amount = cfg_data[bts_pkg::DRIVE_W-1:0];
                bts_pkg::REG_BIAS_OFFSET:
                    cfg_next.bias_offset  = $signed(cfg_data[bts_pkg::BIAS_W-1:0]);
                bts_pkg::REG_OUTPUT_SCALE:
                    cfg_next.output_scale = cfg_data[bts_pkg::SCALE_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_gain   <= bts_pkg::RST_INPUT_GAIN;
            cfg_reg.drive_amount <= bts_pkg::RST_DRIVE_AMOUNT;
            cfg_reg.bias_offset  <= bts_pkg::RST_BIAS_OFFSET;
            cfg_reg.output_scale <= bts_pkg::RST_OUTPUT_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (sample_stream.valid),
        .in_ready  (sample_stream.ready),
        .sample    (sample_stream.sample_in),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    bts_tanh u_tanh (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (shaped_valid),
        .out_ready (shaped_ready),
        .out_data  (shaped_data)
    );

    bts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (shaped_valid),
        .in_ready  (shaped_ready),
        .in_data   (shaped_data),
        .out_valid (result_stream.valid),
        .out_ready (result_stream.ready),
        .sample    (result_stream.sample_out)
    );

endmodule
